/* rtl/whp_pkg.sv */
// Shared types and constants for the WAVE header parser and sample extractor.
`timescale 1ns / 1ps

package whp_pkg;

  // Chunk identifiers as they appear in stream order (first byte in the top octet)
  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] PCM_TAG      = 16'd1;

  // Default depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_RIFF_ID   = 3'd1,
    ERR_WAVE_ID   = 3'd2,
    ERR_FMT_SIZE  = 3'd3,
    ERR_NOT_PCM   = 3'd4,
    ERR_BITS      = 3'd5,
    ERR_ALIGN     = 3'd6,
    ERR_DATA_SIZE = 3'd7
  } err_e;

  typedef enum logic [1:0] {
    CMD_ERROR    = 2'd0,
    CMD_FMT_END  = 2'd1,
    CMD_DATA_HDR = 2'd2,
    CMD_SAMPLE   = 2'd3
  } cmd_op_e;

  typedef enum logic [2:0] {
    SLOT_NONE = 3'd0,
    SLOT_L_LO = 3'd1,
    SLOT_L_HI = 3'd2,
    SLOT_R_LO = 3'd3,
    SLOT_R_HI = 3'd4
  } slot_e;

  // One classified transaction from front to back
  typedef struct packed {
    cmd_op_e     op;
    err_e        code;
    logic [31:0] size;
    logic [7:0]  data;
    slot_e       slot;
    logic        frame_end;
    logic        last;
  } cmd_t;

  // Fields taken from the fmt chunk
  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] align;
    logic [15:0] bits;
  } fmt_t;

endpackage

/* rtl/whp_front.sv */
// Front end: byte-level RIFF/WAVE walker that classifies each byte into back-end commands.
`timescale 1ns / 1ps

module whp_front import whp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] byte_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o,
  output fmt_t       fmt_o
);

  typedef enum logic [3:0] {
    PH_RIFF, PH_WAVE, PH_FMT_HDR, PH_FMT_SKIP, PH_FMT_BODY, PH_FMT_EXTRA,
    PH_DATA_HDR, PH_DATA_SKIP, PH_DATA, PH_DONE, PH_ERR
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] id_q, id_d;
  logic [31:0] size_q, size_d;
  fmt_t        fmt_q, fmt_d;
  logic [15:0] fidx_q, fidx_d;

  logic        accept;
  logic        hdr_last;
  logic [31:0] hdr_id, hdr_size;
  logic [3:0]  body_idx;
  logic [16:0] fidx_inc;
  logic        frame_end;
  slot_e       slot;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fmt_o      = fmt_q;

  // Chunk header: four id bytes shifted in, then a little-endian size
  assign hdr_last = (cnt_q == 32'd7);
  assign hdr_id   = (cnt_q < 32'd4) ? {id_q[23:0], byte_i} : id_q;
  assign hdr_size = (cnt_q < 32'd4) ? size_q : {byte_i, size_q[31:8]};
  assign body_idx = cnt_q[3:0];
  assign fidx_inc = {1'b0, fidx_q} + 17'd1;
  assign frame_end = (fidx_inc >= {1'b0, fmt_q.align});

  always_comb begin
    slot = SLOT_NONE;
    if (fmt_q.bits == 16'd8) begin
      unique case (fidx_q)
        16'd0:   slot = SLOT_L_LO;
        16'd1:   slot = SLOT_R_LO;
        default: slot = SLOT_NONE;
      endcase
    end else begin
      unique case (fidx_q)
        16'd0:   slot = SLOT_L_LO;
        16'd1:   slot = SLOT_L_HI;
        16'd2:   slot = SLOT_R_LO;
        16'd3:   slot = SLOT_R_HI;
        default: slot = SLOT_NONE;
      endcase
    end
  end

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    id_d       = id_q;
    size_d     = size_q;
    fmt_d      = fmt_q;
    fidx_d     = fidx_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    if (accept) begin
      unique case (phase_q)
        PH_RIFF: begin
          id_d   = hdr_id;
          size_d = hdr_size;
          cnt_d  = cnt_q + 32'd1;
          if (hdr_last) begin
            cnt_d = '0;
            if (hdr_id != ID_RIFF) begin
              cmd_push_o = 1'b1;
              cmd_o.op   = CMD_ERROR;
              cmd_o.code = ERR_RIFF_ID;
              phase_d    = PH_ERR;
            end else begin
              phase_d = PH_WAVE;
            end
          end
        end
        PH_WAVE: begin
          id_d  = {id_q[23:0], byte_i};
          cnt_d = cnt_q + 32'd1;
          if (cnt_q == 32'd3) begin
            cnt_d = '0;
            if ({id_q[23:0], byte_i} != ID_WAVE) begin
              cmd_push_o = 1'b1;
              cmd_o.op   = CMD_ERROR;
              cmd_o.code = ERR_WAVE_ID;
              phase_d    = PH_ERR;
            end else begin
              phase_d = PH_FMT_HDR;
            end
          end
        end
        PH_FMT_HDR, PH_DATA_HDR: begin
          id_d   = hdr_id;
          size_d = hdr_size;
          cnt_d  = cnt_q + 32'd1;
          if (hdr_last) begin
            cnt_d = '0;
            if (phase_q == PH_FMT_HDR && hdr_id == ID_FMT) begin
              if (hdr_size < FMT_BODY_LEN) begin
                cmd_push_o = 1'b1;
                cmd_o.op   = CMD_ERROR;
                cmd_o.code = ERR_FMT_SIZE;
                phase_d    = PH_ERR;
              end else begin
                phase_d = PH_FMT_BODY;
              end
            end else if (phase_q == PH_DATA_HDR && hdr_id == ID_DATA) begin
              // size check against the alignment is left to the back end
              cmd_push_o = 1'b1;
              cmd_o.op   = CMD_DATA_HDR;
              cmd_o.size = hdr_size;
              if (hdr_size == '0) begin
                phase_d = PH_DONE;
              end else begin
                cnt_d   = hdr_size;
                fidx_d  = '0;
                phase_d = PH_DATA;
              end
            end else if (hdr_size != '0) begin
              cnt_d   = hdr_size;
              phase_d = (phase_q == PH_FMT_HDR) ? PH_FMT_SKIP : PH_DATA_SKIP;
            end
          end
        end
        PH_FMT_SKIP, PH_DATA_SKIP, PH_FMT_EXTRA: begin
          cnt_d = cnt_q - 32'd1;
          if (cnt_q == 32'd1) begin
            phase_d = (phase_q == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
          end
        end
        PH_FMT_BODY: begin
          unique case (body_idx) inside
            4'd0:          fmt_d.tag = {8'h00, byte_i};
            4'd1:          fmt_d.tag[15:8] = byte_i;
            4'd2:          fmt_d.channels = {8'h00, byte_i};
            4'd3:          fmt_d.channels[15:8] = byte_i;
            [4'd4:4'd7]:   fmt_d.rate = {byte_i, fmt_q.rate[31:8]};
            4'd12:         fmt_d.align = {8'h00, byte_i};
            4'd13:         fmt_d.align[15:8] = byte_i;
            4'd14:         fmt_d.bits = {8'h00, byte_i};
            4'd15:         fmt_d.bits[15:8] = byte_i;
            default:       ;
          endcase
          cnt_d = cnt_q + 32'd1;
          if (body_idx == 4'd15) begin
            // checks run in the back end; a failure there freezes it
            cmd_push_o = 1'b1;
            cmd_o.op   = CMD_FMT_END;
            if (size_q > FMT_BODY_LEN) begin
              cnt_d   = size_q - FMT_BODY_LEN;
              phase_d = PH_FMT_EXTRA;
            end else begin
              cnt_d   = '0;
              phase_d = PH_DATA_HDR;
            end
          end
        end
        PH_DATA: begin
          cnt_d  = cnt_q - 32'd1;
          fidx_d = frame_end ? 16'd0 : fidx_inc[15:0];
          if (slot != SLOT_NONE || frame_end) begin
            cmd_push_o      = 1'b1;
            cmd_o.op        = CMD_SAMPLE;
            cmd_o.data      = byte_i;
            cmd_o.slot      = slot;
            cmd_o.frame_end = frame_end;
            cmd_o.last      = frame_end && (cnt_q == 32'd1);
          end
          if (frame_end && cnt_q == 32'd1) begin
            phase_d = PH_DONE;
          end
        end
        PH_DONE, PH_ERR: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      cnt_q   <= '0;
      id_q    <= '0;
      size_q  <= '0;
      fmt_q   <= '0;
      fidx_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      id_q    <= id_d;
      size_q  <= size_d;
      fmt_q   <= fmt_d;
      fidx_q  <= fidx_d;
    end
  end

endmodule

/* rtl/whp_queue.sv */
// Small register FIFO carrying commands from the front end to the back end.
`timescale 1ns / 1ps

module whp_queue import whp_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full command queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty command queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("command queue count beyond depth");

endmodule

/* rtl/whp_back.sv */
// Back end: fmt checks, data-size remainder unit, frame assembly and result register.
`timescale 1ns / 1ps

module whp_back import whp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic               q_empty_i,
  output logic               pop_o,
  input  fmt_t               fmt_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [2:0]         error_code_o,
  output logic [15:0]        channel_count_o,
  output logic [4:0]         sample_bits_o,
  output logic [31:0]        sample_rate_o,
  output logic signed [15:0] left_sample_o,
  output logic signed [15:0] right_sample_o,
  output logic               last_frame_o
);

  typedef enum logic [1:0] {B_RUN, B_DIV, B_CHK, B_ERR} bstate_e;

  bstate_e     state_q, state_d;
  logic [4:0]  div_cnt_q, div_cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] dvd_q, dvd_d;
  logic [15:0] lacc_q, lacc_d, racc_q, racc_d;
  logic        out_valid_q, out_valid_d;

  kind_e       kind_q;
  err_e        err_q;
  logic [15:0] ch_q;
  logic [4:0]  bits_q;
  logic [31:0] rate_q;
  logic [15:0] left_q, right_q;
  logic        last_q;

  logic        slot_free;
  logic        emit;
  kind_e       e_kind;
  err_e        e_err;
  logic        e_fmt;
  logic [15:0] e_left, e_right;
  logic        e_last;
  logic [16:0] trial;
  logic [15:0] lnext, rnext;
  logic        align_ok;

  assign slot_free = !out_valid_q || out_ready_i;
  assign trial     = {rem_q, dvd_q[31]};

  // align * 8 == channels * bits, with bits already known to be 8 or 16
  assign align_ok = (fmt_i.align != '0) &&
                    ((fmt_i.bits == 16'd8) ? (fmt_i.align == fmt_i.channels)
                                           : ({1'b0, fmt_i.align} == {fmt_i.channels, 1'b0}));

  always_comb begin
    lnext = lacc_q;
    rnext = racc_q;
    case (cmd_i.slot)
      SLOT_L_LO: lnext = {8'h00, cmd_i.data};
      SLOT_L_HI: lnext = {cmd_i.data, lacc_q[7:0]};
      SLOT_R_LO: rnext = {8'h00, cmd_i.data};
      SLOT_R_HI: rnext = {cmd_i.data, racc_q[7:0]};
      default:   ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    div_cnt_d   = div_cnt_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    lacc_d      = lacc_q;
    racc_d      = racc_q;
    pop_o       = 1'b0;
    emit        = 1'b0;
    e_kind      = KIND_ERROR;
    e_err       = ERR_NONE;
    e_fmt       = 1'b0;
    e_left      = '0;
    e_right     = '0;
    e_last      = 1'b0;
    unique case (state_q)
      B_RUN: begin
        if (!q_empty_i && slot_free) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            CMD_ERROR: begin
              emit    = 1'b1;
              e_err   = cmd_i.code;
              state_d = B_ERR;
            end
            CMD_FMT_END: begin
              emit = 1'b1;
              if (fmt_i.tag != PCM_TAG) begin
                e_err   = ERR_NOT_PCM;
                state_d = B_ERR;
              end else if (fmt_i.bits != 16'd8 && fmt_i.bits != 16'd16) begin
                e_err   = ERR_BITS;
                state_d = B_ERR;
              end else if (!align_ok) begin
                e_err   = ERR_ALIGN;
                state_d = B_ERR;
              end else begin
                e_kind = KIND_FORMAT;
                e_fmt  = 1'b1;
              end
            end
            CMD_DATA_HDR: begin
              dvd_d     = cmd_i.size;
              rem_d     = '0;
              div_cnt_d = '0;
              lacc_d    = '0;
              racc_d    = '0;
              state_d   = B_DIV;
            end
            CMD_SAMPLE: begin
              if (cmd_i.frame_end) begin
                emit    = 1'b1;
                e_kind  = KIND_FRAME;
                e_fmt   = 1'b1;
                e_left  = lnext;
                e_right = rnext;
                e_last  = cmd_i.last;
                lacc_d  = '0;
                racc_d  = '0;
              end else begin
                lacc_d = lnext;
                racc_d = rnext;
              end
            end
            default: ;
          endcase
        end
      end
      B_DIV: begin
        // restoring remainder, one dividend bit per cycle
        rem_d     = (trial >= {1'b0, fmt_i.align}) ? 16'(trial - {1'b0, fmt_i.align})
                                                  : trial[15:0];
        dvd_d     = {dvd_q[30:0], 1'b0};
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == 5'd31) begin
          state_d = B_CHK;
        end
      end
      B_CHK: begin
        if (rem_q == '0) begin
          state_d = B_RUN;
        end else if (slot_free) begin
          emit    = 1'b1;
          e_err   = ERR_DATA_SIZE;
          state_d = B_ERR;
        end
      end
      B_ERR: begin
        pop_o = !q_empty_i;
      end
      default: ;
    endcase
    out_valid_d = emit ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_RUN;
      div_cnt_q   <= '0;
      rem_q       <= '0;
      dvd_q       <= '0;
      lacc_q      <= '0;
      racc_q      <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_FRAME;
      err_q       <= ERR_NONE;
      ch_q        <= '0;
      bits_q      <= '0;
      rate_q      <= '0;
      left_q      <= '0;
      right_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      rem_q       <= rem_d;
      dvd_q       <= dvd_d;
      lacc_q      <= lacc_d;
      racc_q      <= racc_d;
      out_valid_q <= out_valid_d;
      if (emit) begin
        kind_q  <= e_kind;
        err_q   <= e_err;
        ch_q    <= e_fmt ? fmt_i.channels : 16'd0;
        bits_q  <= e_fmt ? fmt_i.bits[4:0] : 5'd0;
        rate_q  <= e_fmt ? fmt_i.rate : 32'd0;
        left_q  <= e_left;
        right_q <= e_right;
        last_q  <= e_last;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign error_code_o    = err_q;
  assign channel_count_o = ch_q;
  assign sample_bits_o   = bits_q;
  assign sample_rate_o   = rate_q;
  assign left_sample_o   = left_q;
  assign right_sample_o  = right_q;
  assign last_frame_o    = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_ERR) |=> (state_q == B_ERR))
    else $error("error state left before reset");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV || state_q == B_CHK) |-> !pop_o)
    else $error("command popped while the remainder unit is busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_ERROR) |->
      (ch_q == '0 && rate_q == '0 && left_q == '0 && right_q == '0 && !last_q))
    else $error("error result carries non-zero fields");

endmodule

/* rtl/wav_header_parser_sample_extractor.sv */
// Top level of the RIFF WAVE PCM header parser and sample-frame extractor.
`timescale 1ns / 1ps

// Takes a WAVE file one byte per transaction on the input channel, checks the
// RIFF and WAVE ids, walks chunks to "fmt ", checks PCM / 8 or 16 bits /
// alignment, then walks to "data" and gives one result per sample frame with
// the first two channels (8-bit raw, 16-bit signed). A format-accepted result
// precedes the frames; any error is reported once and the block then swallows
// every further byte until reset. Odd chunk sizes are not padded.
// Rate: the front end takes one byte per cycle while its command queue has
// room, and the back end retires one command per cycle when the result
// register is free. On the data chunk header the back end first works out
// the size-versus-alignment remainder (one dividend bit per cycle); bytes
// keep arriving into the queue meanwhile and the input stalls once it fills.
// A result register sits between back end and output, so a pending result
// does not stop input bytes being taken until the queue has filled.

module wav_header_parser_sample_extractor import whp_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         byte_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [2:0]         error_code_o,
  output logic [15:0]        channel_count_o,
  output logic [4:0]         sample_bits_o,
  output logic [31:0]        sample_rate_o,
  output logic signed [15:0] left_sample_o,
  output logic signed [15:0] right_sample_o,
  output logic               last_frame_o
);

  cmd_t push_cmd, head_cmd;
  logic push, pop, q_full, q_empty;
  fmt_t fmt;

  // front: byte walker and classifier
  whp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .byte_i     (byte_in_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .cmd_push_o (push),
    .cmd_o      (push_cmd),
    .fmt_o      (fmt)
  );

  // decoupling queue
  whp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: checks, remainder unit, frame assembly, result register
  whp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (head_cmd),
    .q_empty_i       (q_empty),
    .pop_o           (pop),
    .fmt_i           (fmt),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .error_code_o    (error_code_o),
    .channel_count_o (channel_count_o),
    .sample_bits_o   (sample_bits_o),
    .sample_rate_o   (sample_rate_o),
    .left_sample_o   (left_sample_o),
    .right_sample_o  (right_sample_o),
    .last_frame_o    (last_frame_o)
  );

endmodule
